>>> hw/rtl/rpo_pkg.sv
`default_nettype none
package rpo_pkg;

   localparam int CNT_W           = 7;
   localparam int NORM_PERIOD_DEF = 100;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int ITER_W          = 6;
   localparam int SQRT_STEPS      = 32;
   localparam int DIV_STEPS       = 62;

   localparam logic signed [31:0] ONE_Q30  = 32'sh4000_0000;
   localparam logic signed [15:0] AMP_RST  = 16'sd16384;

   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIN     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPLEX_MODE = 2'd3;

   typedef enum logic [2:0] {
      MS_AMP_RE, MS_AMP_IM, MS_PR_SC, MS_PI_SS,
      MS_PR_SS, MS_PI_SC, MS_PR_PR, MS_PI_PI
   } mul_sel_type;

   typedef enum logic [2:0] {
      AO_NONE, AO_LOAD, AO_ADD, AO_SUB, AO2_LOAD, AO2_ADD, AO_OUT_RE, AO_OUT_IM
   } acc_op_type;

   typedef enum logic [3:0] {
      MO_NONE, MO_PHASE_UPD, MO_SQRT_INIT, MO_SQRT_STEP, MO_DIV_INIT_RE,
      MO_DIV_INIT_IM, MO_DIV_STEP, MO_DIV_DONE_RE, MO_DIV_DONE_IM, MO_OUT_LOAD
   } misc_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      misc_op_type misc_op;
   } dp_cmd_type;

   typedef struct packed {
      logic mag_zero;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_MUL6,
      ST_UPD, ST_NMUL0, ST_NMUL1, ST_NMUL2, ST_SQRT, ST_CHECK,
      ST_DIVI_RE, ST_DIV_RE, ST_DIVD_RE, ST_DIVI_IM, ST_DIV_IM, ST_DIVD_IM, ST_OUT
   } ctrl_state_type;

endpackage
`default_nettype wire

>>> hw/rtl/recursive_phasor_oscillator_unit.sv
// Tone source: each accepted item with tick set yields one sample, amplitude times the
// current unit phasor, after which the phasor is rotated by the step (one 32x32
// multiplier, used six times). The sample is loaded into the result register in ST_OUT,
// after the shared multiplier sequence and the phasor update, and only once that register
// is free; the next item is taken when the unit is back in ST_IDLE. Every NORM_PERIOD-th
// sample first renormalizes the phasor with a 32-step square root and two 62-step
// restoring divisions (the divisions are skipped when the magnitude is zero). An item
// with tick clear is taken and gives no result. One item is in work at a time; the
// result register holds the sample while the next item is accepted.
`default_nettype none
module recursive_phasor_oscillator_unit
   import rpo_pkg::*;
#(
   parameter int NORM_PERIOD = NORM_PERIOD_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_tick,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [15:0]         rsp_sample_re,
   output logic signed [15:0]         rsp_sample_im,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rpo_ctrl #(
      .NORM_PERIOD(NORM_PERIOD)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_tick  (req_tick),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rpo_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_sample_re    (rsp_sample_re),
      .rsp_sample_im    (rsp_sample_im)
   );

endmodule
`default_nettype wire

>>> hw/rtl/rpo_datapath.sv
`default_nettype none
module rpo_datapath
   import rpo_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   output logic signed [15:0]         rsp_sample_re,
   output logic signed [15:0]         rsp_sample_im
);

   function automatic logic signed [31:0] sat_step(input logic signed [31:0] v);
      if (v > ONE_Q30) begin
         return ONE_Q30;
      end else if (v < -ONE_Q30) begin
         return -ONE_Q30;
      end
      return v;
   endfunction

   function automatic logic signed [15:0] scale_sat(input logic signed [63:0] p);
      logic signed [63:0] t;
      logic signed [33:0] s;
      t = p + 64'sd536870912;
      s = t[63:30];
      if (s > 34'sd32767) begin
         return 16'sh7FFF;
      end else if (s < -34'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   function automatic logic signed [31:0] rnd_sat32(input logic signed [64:0] a);
      logic signed [64:0] t;
      logic signed [34:0] s;
      t = a + 65'sd536870912;
      s = t[64:30];
      if (s > 35'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (s < -35'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] norm_res(input logic [61:0] q, input logic neg);
      logic [31:0] s;
      logic        big;
      big = (|q[61:32]) || (q[31] && (|q[30:0]));
      s   = big ? 32'h8000_0000 : q[31:0];
      if (neg) begin
         return -$signed(s);
      end
      return s[31] ? 32'sh7FFF_FFFF : $signed(s);
   endfunction

   logic signed [15:0] amp_ff;
   logic signed [31:0] sc_ff, ss_ff;
   logic               cmode_ff;
   logic signed [31:0] pr_ff, pr_in, pi_ff, pi_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [64:0] acc_ff, acc_in, acc2_ff, acc2_in;
   logic signed [15:0] samp_re_ff, samp_re_in, samp_im_ff, samp_im_in;
   logic signed [15:0] out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic [33:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic [61:0]        div_ff, div_in;
   logic signed [31:0] mul_a, mul_b;
   logic signed [64:0] prod_x;
   logic [35:0]        sq_rem, sq_trial;
   logic [32:0]        dv_rem;
   logic [31:0]        abs_re, abs_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff   <= AMP_RST;
         sc_ff    <= ONE_Q30;
         ss_ff    <= '0;
         cmode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_AMPLITUDE:    amp_ff   <= csr_write_data[15:0];
            CSR_STEP_COS:     sc_ff    <= sat_step(csr_write_data);
            CSR_STEP_SIN:     ss_ff    <= sat_step(csr_write_data);
            CSR_COMPLEX_MODE: cmode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cmd.mul_sel)
         MS_AMP_RE: begin mul_a = 32'(amp_ff); mul_b = pr_ff; end
         MS_AMP_IM: begin mul_a = 32'(amp_ff); mul_b = pi_ff; end
         MS_PR_SC:  begin mul_a = pr_ff; mul_b = sc_ff; end
         MS_PI_SS:  begin mul_a = pi_ff; mul_b = ss_ff; end
         MS_PR_SS:  begin mul_a = pr_ff; mul_b = ss_ff; end
         MS_PI_SC:  begin mul_a = pi_ff; mul_b = sc_ff; end
         MS_PR_PR:  begin mul_a = pr_ff; mul_b = pr_ff; end
         MS_PI_PI:  begin mul_a = pi_ff; mul_b = pi_ff; end
         default:   begin mul_a = pr_ff; mul_b = pr_ff; end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      prod_x     = 65'(prod_ff);
      abs_re     = pr_ff[31] ? 32'(-pr_ff) : pr_ff;
      abs_im     = pi_ff[31] ? 32'(-pi_ff) : pi_ff;
      sq_rem     = {rem_ff, acc_ff[63:62]};
      sq_trial   = {2'b00, root_ff, 2'b01};
      dv_rem     = {rem_ff[31:0], div_ff[61]};
      acc_in     = acc_ff;
      acc2_in    = acc2_ff;
      samp_re_in = samp_re_ff;
      samp_im_in = samp_im_ff;
      out_re_in  = out_re_ff;
      out_im_in  = out_im_ff;
      pr_in      = pr_ff;
      pi_in      = pi_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      div_in     = div_ff;

      unique case (cmd.acc_op)
         AO_LOAD:   acc_in  = prod_x;
         AO_ADD:    acc_in  = acc_ff + prod_x;
         AO_SUB:    acc_in  = acc_ff - prod_x;
         AO2_LOAD:  acc2_in = prod_x;
         AO2_ADD:   acc2_in = acc2_ff + prod_x;
         AO_OUT_RE: samp_re_in = scale_sat(prod_ff);
         AO_OUT_IM: samp_im_in = cmode_ff ? scale_sat(prod_ff) : 16'sd0;
         default: ;
      endcase

      unique case (cmd.misc_op)
         MO_PHASE_UPD: begin
            pr_in = rnd_sat32(acc_ff);
            pi_in = rnd_sat32(acc2_ff);
         end
         MO_SQRT_INIT: begin
            rem_in  = '0;
            root_in = '0;
         end
         MO_SQRT_STEP: begin
            acc_in = acc_ff <<< 2;
            if (sq_rem >= sq_trial) begin
               rem_in  = 34'(sq_rem - sq_trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = sq_rem[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
         end
         MO_DIV_INIT_RE: begin
            div_in = {abs_re, 30'd0} + {31'd0, root_ff[31:1]};
            rem_in = '0;
         end
         MO_DIV_INIT_IM: begin
            div_in = {abs_im, 30'd0} + {31'd0, root_ff[31:1]};
            rem_in = '0;
         end
         MO_DIV_STEP: begin
            if (dv_rem >= {1'b0, root_ff}) begin
               rem_in = {1'b0, 33'(dv_rem - {1'b0, root_ff})};
               div_in = {div_ff[60:0], 1'b1};
            end else begin
               rem_in = {1'b0, dv_rem};
               div_in = {div_ff[60:0], 1'b0};
            end
         end
         MO_DIV_DONE_RE: pr_in = norm_res(div_ff, pr_ff[31]);
         MO_DIV_DONE_IM: pi_in = norm_res(div_ff, pi_ff[31]);
         MO_OUT_LOAD: begin
            out_re_in = samp_re_ff;
            out_im_in = samp_im_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_ff <= ONE_Q30;
         pi_ff <= '0;
      end else begin
         pr_ff <= pr_in;
         pi_ff <= pi_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      acc2_ff    <= acc2_in;
      samp_re_ff <= samp_re_in;
      samp_im_ff <= samp_im_in;
      out_re_ff  <= out_re_in;
      out_im_ff  <= out_im_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      div_ff     <= div_in;
   end

   assign status.mag_zero = (root_ff == '0);
   assign rsp_sample_re   = out_re_ff;
   assign rsp_sample_im   = out_im_ff;

endmodule
`default_nettype wire

>>> hw/rtl/rpo_ctrl.sv
`default_nettype none
module rpo_ctrl
   import rpo_pkg::*;
#(
   parameter int NORM_PERIOD = NORM_PERIOD_DEF
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_tick,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   localparam logic [CNT_W-1:0]  PERIOD    = CNT_W'(NORM_PERIOD);
   localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQRT_STEPS - 1);
   localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_STEPS - 1);

   ctrl_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_nx;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_free     = !rsp_valid_ff || !rsp_stall;
      cnt_nx       = cnt_ff + 1'b1;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.mul_sel  = MS_PR_PR;
      cmd.acc_op   = AO_NONE;
      cmd.misc_op  = MO_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_tick) begin
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            cmd.mul_sel = MS_AMP_RE;
            state_in    = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_sel = MS_AMP_IM;
            cmd.acc_op  = AO_OUT_RE;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_sel = MS_PR_SC;
            cmd.acc_op  = AO_OUT_IM;
            state_in    = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul_sel = MS_PI_SS;
            cmd.acc_op  = AO_LOAD;
            state_in    = ST_MUL4;
         end
         ST_MUL4: begin
            cmd.mul_sel = MS_PR_SS;
            cmd.acc_op  = AO_SUB;
            state_in    = ST_MUL5;
         end
         ST_MUL5: begin
            cmd.mul_sel = MS_PI_SC;
            cmd.acc_op  = AO2_LOAD;
            state_in    = ST_MUL6;
         end
         ST_MUL6: begin
            cmd.acc_op = AO2_ADD;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            cmd.misc_op = MO_PHASE_UPD;
            if (cnt_nx >= PERIOD) begin
               cnt_in   = '0;
               state_in = ST_NMUL0;
            end else begin
               cnt_in   = cnt_nx;
               state_in = ST_OUT;
            end
         end
         ST_NMUL0: begin
            cmd.mul_sel = MS_PR_PR;
            state_in    = ST_NMUL1;
         end
         ST_NMUL1: begin
            cmd.mul_sel = MS_PI_PI;
            cmd.acc_op  = AO_LOAD;
            state_in    = ST_NMUL2;
         end
         ST_NMUL2: begin
            cmd.acc_op  = AO_ADD;
            cmd.misc_op = MO_SQRT_INIT;
            iter_in     = '0;
            state_in    = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.misc_op = MO_SQRT_STEP;
            iter_in     = iter_ff + 1'b1;
            if (iter_ff == SQRT_LAST) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.mag_zero ? ST_OUT : ST_DIVI_RE;
         end
         ST_DIVI_RE: begin
            cmd.misc_op = MO_DIV_INIT_RE;
            iter_in     = '0;
            state_in    = ST_DIV_RE;
         end
         ST_DIV_RE: begin
            cmd.misc_op = MO_DIV_STEP;
            iter_in     = iter_ff + 1'b1;
            if (iter_ff == DIV_LAST) begin
               state_in = ST_DIVD_RE;
            end
         end
         ST_DIVD_RE: begin
            cmd.misc_op = MO_DIV_DONE_RE;
            state_in    = ST_DIVI_IM;
         end
         ST_DIVI_IM: begin
            cmd.misc_op = MO_DIV_INIT_IM;
            iter_in     = '0;
            state_in    = ST_DIV_IM;
         end
         ST_DIV_IM: begin
            cmd.misc_op = MO_DIV_STEP;
            iter_in     = iter_ff + 1'b1;
            if (iter_ff == DIV_LAST) begin
               state_in = ST_DIVD_IM;
            end
         end
         ST_DIVD_IM: begin
            cmd.misc_op = MO_DIV_DONE_IM;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.misc_op  = MO_OUT_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_tick) |=> (state_ff == ST_MUL0))
      else $error("accepted tick did not start the sample sequence");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.misc_op == MO_OUT_LOAD) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while held");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < PERIOD)
      else $error("sample counter beyond period");

   a_norm_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NMUL0) |-> (cnt_ff == '0))
      else $error("normalization started without counter wrap");

endmodule
`default_nettype wire

>>> tb/sv/recursive_phasor_oscillator_unit_tb.sv
`timescale 1ns / 100ps
module recursive_phasor_oscillator_unit_tb;
   import rpo_pkg::*;

   localparam int  IDLE_LIMIT = 5000;
   localparam int  LONG_HOLD  = 400;
   localparam int  SETTLE     = 200;
   localparam longint ONE     = 64'sd1073741824;

   typedef enum logic {ROW_CSR, ROW_TICK} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  tick;
      bit                    typed;
      logic signed [15:0]    re;
      logic signed [15:0]    im;
   } stim_row_type;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_tick = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic req_stall;
   logic rsp_valid;
   logic signed [15:0] rsp_sample_re;
   logic signed [15:0] rsp_sample_im;

   recursive_phasor_oscillator_unit uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   longint osc_amp, osc_cos, osc_sin, osc_re, osc_im;
   bit     osc_cplx;
   int     osc_count;

   sample_type expected_samples[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  hold_toggle = 0;
   bit  hold_seen = 0;
   int  hold_left = 0;
   int  stall_mode = 0;
   int  burst_left = 0;
   bit  smooth_send = 0;

   function automatic longint sat_to(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat32(longint v);
      return sat_to(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic logic signed [15:0] scale_sample(longint p);
      return 16'(sat_to((osc_amp * p + (ONE >>> 1)) >>> 30, -32768, 32767));
   endfunction

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unit_part(longint p, longint unsigned mag);
      longint unsigned a, q;
      a = p < 0 ? -p : p;
      q = ((a << 30) + (mag >> 1)) / mag;
      if (q > 64'd2147483648) q = 64'd2147483648;
      return sat32(p < 0 ? -longint'(q) : longint'(q));
   endfunction

   function automatic void osc_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_AMPLITUDE:    osc_amp = longint'($signed(d[15:0]));
         CSR_STEP_COS:     osc_cos = sat_to(longint'($signed(d)), -ONE, ONE);
         CSR_STEP_SIN:     osc_sin = sat_to(longint'($signed(d)), -ONE, ONE);
         CSR_COMPLEX_MODE: osc_cplx = d[0];
         default: ;
      endcase
   endfunction

   function automatic sample_type osc_next();
      sample_type s;
      longint nr, ni;
      longint unsigned ar, ai, mag;
      s.re = scale_sample(osc_re);
      s.im = osc_cplx ? scale_sample(osc_im) : 16'sd0;
      nr = (osc_re * osc_cos - osc_im * osc_sin + (ONE >>> 1)) >>> 30;
      ni = (osc_re * osc_sin + osc_im * osc_cos + (ONE >>> 1)) >>> 30;
      osc_re = sat32(nr);
      osc_im = sat32(ni);
      osc_count = (osc_count + 1) & 8'h7f;
      if (osc_count >= NORM_PERIOD_DEF) begin
         ar = osc_re < 0 ? -osc_re : osc_re;
         ai = osc_im < 0 ? -osc_im : osc_im;
         mag = root64(ar * ar + ai * ai);
         osc_count = 0;
         if (mag != 0) begin
            osc_re = unit_part(osc_re, mag);
            osc_im = unit_part(osc_im, mag);
         end
      end
      return s;
   endfunction

   task automatic wait_drained();
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= d;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      osc_write(idx, d);
      @(posedge clock);
   endtask

   task automatic send_tick(logic t, bit typed, sample_type typed_val);
      sample_type s;
      int gap;
      if (!smooth_send && burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_tick <= t;
      do @(posedge clock); while (req_stall);
      if (t) begin
         s = osc_next();
         expected_samples.push_back(typed ? typed_val : s);
      end
   endtask

   task automatic random_phase(int n, int step_kind);
      real th;
      int  i;
      csr_write(CSR_AMPLITUDE, $urandom_range(0, 3) == 0 ?
                ($urandom_range(0, 1) ? 32'h7fff : 32'hffff8000) : $urandom());
      case (step_kind)
         0: begin
            th = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 2.0 * 3.14159;
            csr_write(CSR_STEP_COS, 32'($rtoi($cos(th) * 1073741824.0)));
            csr_write(CSR_STEP_SIN, 32'($rtoi($sin(th) * 1073741824.0)));
         end
         1: begin
            csr_write(CSR_STEP_COS, $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
            csr_write(CSR_STEP_SIN, $urandom_range(0, 1) ? 32'h40000000 : 32'hc0000000);
         end
         2: begin
            csr_write(CSR_STEP_COS, $urandom() | 32'h40000000 & ~32'h80000000);
            csr_write(CSR_STEP_SIN, $urandom() | 32'h80000000 & ~32'h40000000);
         end
         default: begin
            csr_write(CSR_STEP_COS, 32'h0);
            csr_write(CSR_STEP_SIN, 32'h0);
         end
      endcase
      csr_write(CSR_COMPLEX_MODE, $urandom());
      smooth_send = $urandom_range(0, 3) == 0;
      for (i = 0; i < n; i++)
         send_tick($urandom_range(0, 9) != 0, 1'b0, '{default: '0});
      req_valid <= 1'b0;
      wait_drained();
   endtask

   stim_row_type directed[$] = '{
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 1, 16'sd16384, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_CSR, CSR_AMPLITUDE, 32'h0000_7fff, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 1, 16'sd32767, 16'sd0},
      '{ROW_CSR, CSR_AMPLITUDE, 32'hffff_8000, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 1, -16'sd32768, 16'sd0},
      '{ROW_CSR, CSR_AMPLITUDE, 32'h0000_4000, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_CSR, CSR_COMPLEX_MODE, 32'hffff_ffff, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 1, 16'sd16384, 16'sd0},
      '{ROW_CSR, CSR_STEP_COS, 32'h0, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_CSR, CSR_STEP_SIN, 32'h7fff_ffff, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 1, 16'sd16384, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 1, 16'sd0, 16'sd16384},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 1, -16'sd16384, 16'sd0},
      '{ROW_CSR, CSR_STEP_SIN, 32'h8000_0000, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 0, 16'sd0, 16'sd0},
      '{ROW_CSR, CSR_COMPLEX_MODE, 32'hffff_fffe, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_CSR, CSR_COMPLEX_MODE, 32'h1, 1'b0, 0, 16'sd0, 16'sd0},
      '{ROW_TICK, CSR_AMPLITUDE, 32'h0, 1'b1, 0, 16'sd0, 16'sd0}
   };

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= $urandom_range(0, 3) != 0;
         endcase
      end
   end

   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected sample re=%0d im=%0d", rsp_sample_re, rsp_sample_im);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample_re !== want.re || rsp_sample_im !== want.im) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                           want.re, want.im, rsp_sample_re, rsp_sample_im);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("recursive_phasor_oscillator_unit: mismatch");
         $finish;
      end
   end

   initial begin
      sample_type tv;
      int p;
      osc_amp = 16384;
      osc_cos = ONE;
      osc_sin = 0;
      osc_cplx = 0;
      osc_re = ONE;
      osc_im = 0;
      osc_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            req_valid <= 1'b0;
            wait_drained();
            csr_write(directed[i].idx, directed[i].data);
         end else begin
            tv.re = directed[i].re;
            tv.im = directed[i].im;
            send_tick(directed[i].tick, directed[i].typed, tv);
         end
      end
      req_valid <= 1'b0;
      wait_drained();
      for (p = 0; p < 9; p++) begin
         if (p == 2) hold_toggle = ~hold_toggle;
         random_phase($urandom_range(70, 120), p % 3);
      end
      random_phase(150, 3);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("recursive_phasor_oscillator_unit: match");
      end else begin
         $display("recursive_phasor_oscillator_unit: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/rpo_pkg.sv
hw/rtl/rpo_datapath.sv
hw/rtl/rpo_ctrl.sv
hw/rtl/recursive_phasor_oscillator_unit.sv
tb/sv/recursive_phasor_oscillator_unit_tb.sv
